FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, all clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// pre holds at an edge, so post holds at the same edge
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// cond never holds at any edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, pre, post, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: design/ccvg_pkg.sv
// ----------------------------------------------------------------------------
// ccvg_pkg
// Types, constants and fixed-point helpers for the capsule vertex generator.
// ----------------------------------------------------------------------------
package ccvg_pkg;

    localparam int MAX_QUALITY_DEF    = 64;
    localparam int UNIT_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH        = 4;

    // register indexes (byte address / 4)
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_RADIUS      = 3'd0;
    localparam reg_idx_t REG_BODY_LENGTH = 3'd1;
    localparam reg_idx_t REG_QUALITY     = 3'd2;
    localparam reg_idx_t REG_OFFSET_X    = 3'd3;
    localparam reg_idx_t REG_OFFSET_Y    = 3'd4;
    localparam reg_idx_t REG_OFFSET_Z    = 3'd5;
    localparam reg_idx_t REG_STEP_SINE   = 3'd6;
    localparam reg_idx_t REG_STEP_COSINE = 3'd7;

    // mesh sections (code three behaves as the body)
    typedef logic [1:0] sec_t;
    localparam sec_t SEC_BODY = 2'd0;
    localparam sec_t SEC_TOP  = 2'd1;
    localparam sec_t SEC_BOT  = 2'd2;

    typedef struct packed {
        logic        [30:0] radius;
        logic        [30:0] body_length;
        logic        [6:0]  quality;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [15:0] step_sine;
        logic signed [15:0] step_cosine;
    } cfg_t;

    // one classified vertex, front to back
    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               l_plus;
        logic               strip_last;
        logic               mesh_last;
    } vtx_t;

    localparam int VTX_W = $bits(vtx_t);

    function automatic logic signed [15:0] unit_one(input int frac);
        if (frac >= 15)
            return 16'sh7FFF;
        else
            return 16'(1 << frac);
    endfunction

    // round to nearest (ties up) after a right shift of frac, then clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat16(input logic signed [32:0] s,
                                                     input int frac);
        logic signed [47:0] t;
        t = (48'(s) + (48'sd1 <<< (frac - 1))) >>> frac;
        if (t > 48'sd32767)
            return 16'sh7FFF;
        else if (t < -48'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    // a0*b0 +/- a1*b1, rounded and clamped
    function automatic logic signed [15:0] dot2(input logic signed [15:0] a0,
                                                input logic signed [15:0] b0,
                                                input logic signed [15:0] a1,
                                                input logic signed [15:0] b1,
                                                input logic neg,
                                                input int frac);
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [32:0] s;
        p0 = a0 * b0;
        p1 = a1 * b1;
        s  = neg ? (33'(p0) - 33'(p1)) : (33'(p0) + 33'(p1));
        return rnd_sat16(s, frac);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sh0_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -50'sh0_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: design/ccvg_fifo.sv
// ----------------------------------------------------------------------------
// ccvg_fifo
// Small register queue between the walk front end and the position back end.
// ----------------------------------------------------------------------------
module ccvg_fifo
    import ccvg_pkg::*;
#(
    parameter int WIDTH = VTX_W,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/ccvg_front.sv
// ----------------------------------------------------------------------------
// ccvg_front
// Mesh walk: takes requests, picks the unit vector of each vertex, steps
// the rotation recurrence and queues one classified vertex per request.
// ----------------------------------------------------------------------------
module ccvg_front
    import ccvg_pkg::*;
#(
    parameter int MAX_QUALITY    = MAX_QUALITY_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cfg_wr,
    input  logic in_valid,
    output logic in_ready,
    input  logic restart,
    output logic push,
    output vtx_t push_data,
    input  logic q_full
);

    localparam int QW = $clog2(MAX_QUALITY + 1);
    localparam int SW = QW + 2;
    localparam logic signed [15:0] ONE = unit_one(UNIT_FRAC_BITS);

    sec_t               sec_reg,  sec_next;
    logic [QW-1:0]      ring_reg, ring_next;
    logic [SW-1:0]      side_reg, side_next;
    logic               ph_reg,   ph_next;
    logic signed [15:0] a_x_reg, a_y_reg, a_z_reg;
    logic signed [15:0] a_x_next, a_y_next, a_z_next;
    logic signed [15:0] b_x_reg, b_y_reg, b_z_reg;
    logic signed [15:0] b_x_next, b_y_next, b_z_next;
    logic signed [15:0] rs_x_reg, rs_y_reg, rs_x_next, rs_y_next;
    logic signed [15:0] rs1_x_reg, rs1_y_reg, rs1_x_next, rs1_y_next;
    logic               cfg_wr_d_reg;

    logic [QW-1:0]      q_eff;
    logic [SW-1:0]      n_sides;
    sec_t               cur_sec;
    logic [QW-1:0]      cur_ring;
    logic [SW-1:0]      cur_side;
    logic               cur_ph;
    logic signed [15:0] cur_a_x, cur_a_y, cur_a_z, cur_b_x, cur_b_y, cur_b_z;
    logic signed [15:0] cur_rs_x, cur_rs_y;
    logic               cap, last_ring, use_b, s_last;
    logic signed [15:0] ra_y, ra_z, rb_y, rb_z;
    logic               ns_top, ns_from_rs1;
    logic signed [15:0] ns_x, ns_y, nb_x, nb_y;
    logic               rs1_top;

    // clamp quality to 1..MAX_QUALITY
    always_comb
    begin
        if (cfg.quality == '0)
            q_eff = QW'(1);
        else if (int'(cfg.quality) > MAX_QUALITY)
            q_eff = QW'(MAX_QUALITY);
        else
            q_eff = QW'(cfg.quality);
    end
    assign n_sides = {q_eff, 2'b00};

    // hold off in the cycle after a register write so the ring start look-ahead
    // picks up the new coefficients
    assign in_ready = !q_full && !cfg_wr_d_reg;
    assign push     = in_valid && in_ready;

    // walk state as seen by this request (restart applied first)
    always_comb
    begin
        if (restart)
        begin
            cur_sec = SEC_BODY; cur_ring = '0; cur_side = '0; cur_ph = 1'b0;
            cur_a_x = '0; cur_a_y = ONE; cur_a_z = '0;
            cur_b_x = '0; cur_b_y = '0;  cur_b_z = '0;
            cur_rs_x = '0; cur_rs_y = ONE;
        end
        else
        begin
            cur_sec = sec_reg; cur_ring = ring_reg; cur_side = side_reg; cur_ph = ph_reg;
            cur_a_x = a_x_reg; cur_a_y = a_y_reg; cur_a_z = a_z_reg;
            cur_b_x = b_x_reg; cur_b_y = b_y_reg; cur_b_z = b_z_reg;
            cur_rs_x = rs_x_reg; cur_rs_y = rs_y_reg;
        end
    end

    assign cap       = (cur_sec == SEC_TOP) || (cur_sec == SEC_BOT);
    assign last_ring = ({1'b0, cur_ring} + 1'b1) >= {1'b0, q_eff};
    assign use_b     = ((cur_sec == SEC_TOP) && cur_ph) || ((cur_sec == SEC_BOT) && !cur_ph);
    assign s_last    = cur_ph && (cur_side >= n_sides);

    // classified vertex
    always_comb
    begin
        push_data.norm_x     = use_b ? cur_b_y : cur_a_y;
        push_data.norm_y     = cap ? (use_b ? cur_b_x : cur_a_x) : 16'sd0;
        push_data.norm_z     = use_b ? cur_b_z : cur_a_z;
        push_data.l_plus     = (cur_sec == SEC_TOP) || (!cap && cur_ph);
        push_data.strip_last = s_last;
        push_data.mesh_last  = s_last && (cur_sec == SEC_BOT) && last_ring;
    end

    // side step rotations
    assign ra_y = dot2(cfg.step_cosine, cur_a_y, cfg.step_sine, cur_a_z, 1'b1, UNIT_FRAC_BITS);
    assign ra_z = dot2(cfg.step_sine, cur_a_y, cfg.step_cosine, cur_a_z, 1'b0, UNIT_FRAC_BITS);
    assign rb_y = dot2(cfg.step_cosine, cur_b_y, cfg.step_sine, cur_b_z, 1'b1, UNIT_FRAC_BITS);
    assign rb_z = dot2(cfg.step_sine, cur_b_y, cfg.step_cosine, cur_b_z, 1'b0, UNIT_FRAC_BITS);

    // start of the next cap strip: ring start, and b one step towards the pole
    assign ns_from_rs1 = cap && !last_ring;
    assign ns_top      = !cap || ((cur_sec == SEC_TOP) && !last_ring);
    assign ns_x        = ns_from_rs1 ? rs1_x_reg : 16'sd0;
    assign ns_y        = ns_from_rs1 ? rs1_y_reg : ONE;
    assign nb_x = dot2(cfg.step_cosine, ns_x, cfg.step_sine, ns_y, !ns_top, UNIT_FRAC_BITS);
    assign nb_y = dot2(cfg.step_cosine, ns_y, cfg.step_sine, ns_x, ns_top, UNIT_FRAC_BITS);

    // next ring start, kept ready in the background
    assign rs1_top    = (sec_reg == SEC_TOP);
    assign rs1_x_next = dot2(cfg.step_cosine, rs_x_reg, cfg.step_sine, rs_y_reg, !rs1_top,
                             UNIT_FRAC_BITS);
    assign rs1_y_next = dot2(cfg.step_cosine, rs_y_reg, cfg.step_sine, rs_x_reg, rs1_top,
                             UNIT_FRAC_BITS);

    // walk advance
    always_comb
    begin
        sec_next = cur_sec; ring_next = cur_ring; side_next = cur_side; ph_next = cur_ph;
        a_x_next = cur_a_x; a_y_next = cur_a_y; a_z_next = cur_a_z;
        b_x_next = cur_b_x; b_y_next = cur_b_y; b_z_next = cur_b_z;
        rs_x_next = cur_rs_x; rs_y_next = cur_rs_y;
        if (!cur_ph)
            ph_next = 1'b1;
        else
        begin
            ph_next = 1'b0;
            if (cur_side < n_sides)
            begin
                side_next = cur_side + 1'b1;
                a_y_next  = ra_y;
                a_z_next  = ra_z;
                if (cap)
                begin
                    b_y_next = rb_y;
                    b_z_next = rb_z;
                end
            end
            else
            begin
                side_next = '0;
                if (cap && last_ring && (cur_sec == SEC_BOT))
                begin
                    // end of mesh: start over
                    sec_next = SEC_BODY; ring_next = '0;
                    a_x_next = '0; a_y_next = ONE; a_z_next = '0;
                    b_x_next = '0; b_y_next = '0;  b_z_next = '0;
                    rs_x_next = '0; rs_y_next = ONE;
                end
                else
                begin
                    if (!cap)
                    begin
                        sec_next = SEC_TOP; ring_next = '0;
                    end
                    else if (last_ring)
                    begin
                        sec_next = SEC_BOT; ring_next = '0;
                    end
                    else
                        ring_next = cur_ring + 1'b1;
                    rs_x_next = ns_x;
                    rs_y_next = ns_y;
                    a_x_next  = ns_x; a_y_next = ns_y; a_z_next = '0;
                    b_x_next  = nb_x; b_y_next = nb_y; b_z_next = '0;
                end
            end
        end
    end

    // walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg <= SEC_BODY; ring_reg <= '0; side_reg <= '0; ph_reg <= 1'b0;
            a_x_reg <= '0; a_y_reg <= ONE; a_z_reg <= '0;
            b_x_reg <= '0; b_y_reg <= '0;  b_z_reg <= '0;
            rs_x_reg <= '0; rs_y_reg <= ONE;
            rs1_x_reg <= '0; rs1_y_reg <= '0;
            cfg_wr_d_reg <= 1'b0;
        end
        else
        begin
            rs1_x_reg <= rs1_x_next;
            rs1_y_reg <= rs1_y_next;
            cfg_wr_d_reg <= cfg_wr;
            if (push)
            begin
                sec_reg <= sec_next; ring_reg <= ring_next;
                side_reg <= side_next; ph_reg <= ph_next;
                a_x_reg <= a_x_next; a_y_reg <= a_y_next; a_z_reg <= a_z_next;
                b_x_reg <= b_x_next; b_y_reg <= b_y_next; b_z_reg <= b_z_next;
                rs_x_reg <= rs_x_next; rs_y_reg <= rs_y_next;
            end
        end
    end

endmodule

FILE: design/ccvg_back.sv
// ----------------------------------------------------------------------------
// ccvg_back
// Position pipeline: radius products, then offset, half length and
// saturation into the output register.
// ----------------------------------------------------------------------------
module ccvg_back
    import ccvg_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  vtx_t         q_data,
    input  logic         q_empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [143:0] out_data,
    output logic         out_last,
    output logic         out_mesh_last
);

    localparam logic signed [49:0] HALF = 50'sd1 <<< (UNIT_FRAC_BITS - 1);

    logic               v1_reg;
    vtx_t               s1_reg;
    logic signed [47:0] p_x_reg, p_y_reg, p_z_reg;
    logic               v2_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    vtx_t               s2_reg;

    logic               adv1, adv2;
    logic signed [31:0] rad;
    logic signed [49:0] half_len;
    logic signed [49:0] sum_x, sum_y, sum_z;

    assign adv2 = !v2_reg || out_ready;
    assign adv1 = !v1_reg || adv2;
    assign pop  = !q_empty && adv1;
    assign rad  = $signed({1'b0, cfg.radius});
    assign half_len = $signed(50'(cfg.body_length[30:1]));

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= !q_empty;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    // stage one: radius products
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg  <= q_data;
            p_x_reg <= q_data.norm_x * rad;
            p_y_reg <= q_data.norm_y * rad;
            p_z_reg <= q_data.norm_z * rad;
        end
    end

    // stage two: round, offset, half length, clamp
    always_comb
    begin
        sum_x = 50'(cfg.offset_x) + ((50'(p_x_reg) + HALF) >>> UNIT_FRAC_BITS);
        sum_y = 50'(cfg.offset_y) + ((50'(p_y_reg) + HALF) >>> UNIT_FRAC_BITS)
              + (s1_reg.l_plus ? half_len : -half_len);
        sum_z = 50'(cfg.offset_z) + ((50'(p_z_reg) + HALF) >>> UNIT_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            s2_reg    <= s1_reg;
            pos_x_reg <= sat32(sum_x);
            pos_y_reg <= sat32(sum_y);
            pos_z_reg <= sat32(sum_z);
        end
    end

    assign out_valid     = v2_reg;
    assign out_data      = {s2_reg.norm_z, s2_reg.norm_y, s2_reg.norm_x,
                            pos_z_reg, pos_y_reg, pos_x_reg};
    assign out_last      = s2_reg.strip_last;
    assign out_mesh_last = s2_reg.mesh_last;

endmodule

FILE: design/capped_cylinder_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// capped_cylinder_vertex_generator_top
// Path: request beat, queue, back-end radius product and output registers.
// Throughput: one vertex per cycle while the queue has room and m_tready is
// high; s_tready drops for one cycle after each register write.
// Reset: rst_n clears the walk to the first body vertex and loads register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module capped_cylinder_vertex_generator_top
    import ccvg_pkg::*;
#(
    parameter int MAX_QUALITY    = MAX_QUALITY_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [0] restart
    // vertex stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,     // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    output logic         m_tlast,     // strip_last
    output logic [0:0]   m_tuser,     // [0] mesh_last
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     q_push, q_pop, q_full, q_empty;
    vtx_t     q_wdata, q_rdata;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius      <= 31'd65536;
            cfg_reg.body_length <= 31'd65536;
            cfg_reg.quality     <= 7'd1;
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
            cfg_reg.offset_z    <= '0;
            cfg_reg.step_sine   <= 16'sd16384;
            cfg_reg.step_cosine <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_RADIUS:      cfg_reg.radius      <= pwdata[30:0];
                REG_BODY_LENGTH: cfg_reg.body_length <= pwdata[30:0];
                REG_QUALITY:     cfg_reg.quality     <= pwdata[6:0];
                REG_OFFSET_X:    cfg_reg.offset_x    <= pwdata;
                REG_OFFSET_Y:    cfg_reg.offset_y    <= pwdata;
                REG_OFFSET_Z:    cfg_reg.offset_z    <= pwdata;
                REG_STEP_SINE:   cfg_reg.step_sine   <= pwdata[15:0];
                REG_STEP_COSINE: cfg_reg.step_cosine <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_RADIUS:      prdata = {1'b0, cfg_reg.radius};
            REG_BODY_LENGTH: prdata = {1'b0, cfg_reg.body_length};
            REG_QUALITY:     prdata = {25'd0, cfg_reg.quality};
            REG_OFFSET_X:    prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:    prdata = cfg_reg.offset_y;
            REG_OFFSET_Z:    prdata = cfg_reg.offset_z;
            REG_STEP_SINE:   prdata = {{16{cfg_reg.step_sine[15]}}, cfg_reg.step_sine};
            REG_STEP_COSINE: prdata = {{16{cfg_reg.step_cosine[15]}}, cfg_reg.step_cosine};
            default:         prdata = '0;
        endcase
    end

    ccvg_front #(
        .MAX_QUALITY    (MAX_QUALITY),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_wr),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .restart   (s_tdata[0]),
        .push      (q_push),
        .push_data (q_wdata),
        .q_full    (q_full)
    );

    ccvg_fifo #(
        .WIDTH (VTX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    ccvg_back #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_data        (q_rdata),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata),
        .out_last      (m_tlast),
        .out_mesh_last (m_tuser[0])
    );

    // checks
    `ASSERT_IMPLY(a_mesh_ends_strip, m_tvalid && m_tuser[0], m_tlast, "mesh end without strip end")
    `ASSERT_NEVER(a_push_when_full, q_push && q_full, "queue overflow")
    `ASSERT_NEVER(a_pop_when_empty, q_pop && q_empty, "queue underflow")

endmodule
